// ===== hdl/ascii85_stream_encoder_assert.svh =====
// ----------------------------------------------------------------------------
// ascii85 stream encoder assertion macros
// Shared property wrappers, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef ASCII85_STREAM_ENCODER_ASSERT_SVH
`define ASCII85_STREAM_ENCODER_ASSERT_SVH

// same-cycle implication
`define A85_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define A85_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/a85enc_pkg.sv =====
// ----------------------------------------------------------------------------
// a85enc_pkg
// Types and constants shared by the ascii85 stream encoder modules.
// ----------------------------------------------------------------------------
package a85enc_pkg;

  // default depth of the job queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // line length register reset value
  localparam logic [5:0] GPL_RESET = 6'd20;

  // characters
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_Z     = 8'h7A;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_GT    = 8'h3E;

  // base-85 digit extraction: q = (v * DIV85_MAGIC) >> DIV85_SHIFT, exact for 32-bit v
  localparam logic [6:0]  A85_BASE    = 7'd85;
  localparam logic [31:0] DIV85_MAGIC = 32'hC0C0C0C1;
  localparam int          DIV85_SHIFT = 38;
  localparam int          NUM_DIGITS  = 5;

  // emission slots: digits 0..4 (most significant first), then the specials
  localparam int SLOT_Z     = 5;
  localparam int SLOT_NL    = 6;
  localparam int SLOT_TILDE = 7;
  localparam int SLOT_GT    = 8;
  localparam int NUM_SLOTS  = 9;

  // one unit of work for the back end
  typedef struct packed {
    logic [31:0]          word;  // group value, zero padded for a partial group
    logic [NUM_SLOTS-1:0] mask;  // characters to emit, one bit per slot
  } job_t;

  // job queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ===== hdl/a85enc_front.sv =====
// ----------------------------------------------------------------------------
// a85enc_front
// Accepts input bytes, builds 32-bit groups and classifies each finished
// group or stream end into a job for the back end.
// ----------------------------------------------------------------------------
`include "ascii85_stream_encoder_assert.svh"

module a85enc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  input  logic                cfg_wr_en,
  input  logic [5:0]          cfg_wr_data,
  input  a85enc_pkg::qstat_t  qstat,
  output logic                push,
  output a85enc_pkg::job_t    push_job
);

  logic [5:0]  groups_per_line;
  logic [23:0] held;
  logic [23:0] held_next;
  logic [1:0]  pos;
  logic [1:0]  pos_next;
  logic [5:0]  cnt;
  logic [5:0]  cnt_next;

  logic        accept;
  logic        full_group;
  logic [31:0] joined;
  logic [31:0] padded;
  logic [5:0]  limit;
  logic [5:0]  cnt_inc;
  logic        line_end;

  assign in_ready = !qstat.full;
  assign accept   = in_valid && in_ready;

  // group assembly
  assign joined     = {held, data_byte};
  assign full_group = (pos == 2'd3);

  always_comb begin
    case (pos)
      2'd0:    padded = {data_byte, 24'd0};
      2'd1:    padded = {held[7:0], data_byte, 16'd0};
      2'd2:    padded = {held[15:0], data_byte, 8'd0};
      default: padded = joined;
    endcase
  end

  // line length, zero acts like one
  assign limit    = (groups_per_line == 6'd0) ? 6'd1 : groups_per_line;
  assign cnt_inc  = cnt + 6'd1;
  assign line_end = (cnt_inc >= limit);

  // job classification
  always_comb begin
    push_job      = '0;
    push_job.word = full_group ? joined : padded;
    if (full_group) begin
      if (joined == 32'd0) begin
        push_job.mask[a85enc_pkg::SLOT_Z] = 1'b1;
      end else begin
        push_job.mask[4:0] = 5'b11111;
      end
      push_job.mask[a85enc_pkg::SLOT_NL] = line_end;
    end else begin
      case (pos)
        2'd0:    push_job.mask[4:0] = 5'b00011;
        2'd1:    push_job.mask[4:0] = 5'b00111;
        default: push_job.mask[4:0] = 5'b01111;
      endcase
    end
    push_job.mask[a85enc_pkg::SLOT_TILDE] = last_byte;
    push_job.mask[a85enc_pkg::SLOT_GT]    = last_byte;
  end

  assign push = accept && (full_group || last_byte);

  // state update
  always_comb begin
    held_next = held;
    pos_next  = pos;
    cnt_next  = cnt;
    if (accept) begin
      if (full_group) begin
        held_next = '0;
        pos_next  = '0;
        cnt_next  = line_end ? 6'd0 : cnt_inc;
      end else begin
        held_next = joined[23:0];
        pos_next  = pos + 2'd1;
      end
      if (last_byte) begin
        held_next = '0;
        pos_next  = '0;
        cnt_next  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      groups_per_line <= a85enc_pkg::GPL_RESET;
      held            <= '0;
      pos             <= '0;
      cnt             <= '0;
    end else begin
      if (cfg_wr_en) begin
        groups_per_line <= cfg_wr_data;
      end
      held <= held_next;
      pos  <= pos_next;
      cnt  <= cnt_next;
    end
  end

  // stream end leaves an empty group
  `A85_ASSERT_NEXT(a_end_clears_group, accept && last_byte, pos == 2'd0 && cnt == 6'd0, "group state not cleared after last byte")

endmodule

// ===== hdl/a85enc_queue.sv =====
// ----------------------------------------------------------------------------
// a85enc_queue
// Short job queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`include "ascii85_stream_encoder_assert.svh"

module a85enc_queue #(
  parameter int QUEUE_DEPTH = a85enc_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  a85enc_pkg::job_t   push_job,
  input  logic               pop,
  output a85enc_pkg::job_t   pop_job,
  output a85enc_pkg::qstat_t qstat
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  a85enc_pkg::job_t entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign qstat.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);
  assign pop_job     = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `A85_ASSERT_IMPL(a_no_push_full, push, !qstat.full, "job pushed into full queue")
  `A85_ASSERT_IMPL(a_no_pop_empty, pop, !qstat.empty, "job popped from empty queue")

endmodule

// ===== hdl/a85enc_back.sv =====
// ----------------------------------------------------------------------------
// a85enc_back
// Converts queued groups to base-85 digits and emits the characters of each
// job, one per cycle while out_ready allows, through a registered output stage.
// ----------------------------------------------------------------------------
`include "ascii85_stream_encoder_assert.svh"

module a85enc_back (
  input  logic               clk,
  input  logic               rst,
  input  a85enc_pkg::qstat_t qstat,
  input  a85enc_pkg::job_t   pop_job,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_char,
  output logic               out_last
);

  localparam int NS = a85enc_pkg::NUM_SLOTS;
  localparam int ND = a85enc_pkg::NUM_DIGITS;

  // converter
  logic          cv_busy;
  logic          cv_done;
  logic [2:0]    cv_step;
  logic [63:0]   cv_prod;
  logic [31:0]   cv_rem;
  logic [6:0]    cv_dig [ND];
  logic [NS-1:0] cv_mask;
  logic [25:0]   cv_q;
  logic [31:0]   mul_a;
  logic [6:0]    dig_new;
  logic          conv_last;

  // emitter
  logic [NS-1:0] em_mask;
  logic [NS-1:0] em_mask_after;
  logic [NS-1:0] em_sel;
  logic [6:0]    em_dig [ND];
  logic          fire;
  logic          handoff;
  logic [7:0]    char_sel;

  // divide by 85 through the reciprocal product
  assign cv_q      = cv_prod[63:a85enc_pkg::DIV85_SHIFT];
  assign dig_new   = cv_rem[6:0] - 7'(cv_q[6:0] * a85enc_pkg::A85_BASE);
  assign mul_a     = cv_busy ? 32'(cv_q) : pop_job.word;
  assign conv_last = (cv_step == 3'(ND - 1));

  // emitter slot pick, lowest pending slot first
  assign em_sel        = em_mask & (~em_mask + 1'b1);
  assign fire          = (em_mask != '0) && (!out_valid || out_ready);
  assign em_mask_after = fire ? (em_mask & ~em_sel) : em_mask;
  assign handoff       = cv_done && (em_mask_after == '0);
  assign pop           = !qstat.empty && !cv_busy && (!cv_done || handoff);

  always_comb begin
    char_sel = '0;
    for (int i = 0; i < ND; i++) begin
      if (em_sel[i]) begin
        char_sel = {1'b0, em_dig[i]} + a85enc_pkg::CH_BANG;
      end
    end
    if (em_sel[a85enc_pkg::SLOT_Z]) begin
      char_sel = a85enc_pkg::CH_Z;
    end
    if (em_sel[a85enc_pkg::SLOT_NL]) begin
      char_sel = a85enc_pkg::CH_NL;
    end
    if (em_sel[a85enc_pkg::SLOT_TILDE]) begin
      char_sel = a85enc_pkg::CH_TILDE;
    end
    if (em_sel[a85enc_pkg::SLOT_GT]) begin
      char_sel = a85enc_pkg::CH_GT;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cv_busy   <= 1'b0;
      cv_done   <= 1'b0;
      cv_step   <= '0;
      em_mask   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        cv_step <= '0;
        cv_busy <= |pop_job.mask[ND-1:0];
        cv_done <= ~|pop_job.mask[ND-1:0];
      end else if (cv_busy) begin
        cv_step <= cv_step + 3'd1;
        if (conv_last) begin
          cv_busy <= 1'b0;
          cv_done <= 1'b1;
        end
      end else if (handoff) begin
        cv_done <= 1'b0;
      end

      if (handoff) begin
        em_mask <= cv_mask;
      end else begin
        em_mask <= em_mask_after;
      end

      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath, digits shift in least significant first
  always_ff @(posedge clk) begin
    if (pop || cv_busy) begin
      cv_prod <= 64'(mul_a) * 64'(a85enc_pkg::DIV85_MAGIC);
      cv_rem  <= pop ? pop_job.word : 32'(cv_q);
    end
    if (pop) begin
      cv_mask <= pop_job.mask;
    end
    if (cv_busy) begin
      cv_dig[0] <= dig_new;
      for (int i = 1; i < ND; i++) begin
        cv_dig[i] <= cv_dig[i-1];
      end
    end
    if (handoff) begin
      em_dig <= cv_dig;
    end
    if (fire) begin
      out_char <= char_sel;
      out_last <= em_sel[a85enc_pkg::SLOT_GT];
    end
  end

  `A85_ASSERT_IMPL(a_conv_exclusive, cv_busy, !cv_done, "converter busy and done together")
  `A85_ASSERT_NEXT(a_conv_finish, cv_busy && conv_last, cv_done && !cv_busy, "conversion did not finish")
  `A85_ASSERT_IMPL(a_last_is_gt, out_valid && out_last, out_char == a85enc_pkg::CH_GT, "last flag on a character other than the end marker")

endmodule

// ===== hdl/ascii85_stream_encoder.sv =====
// ----------------------------------------------------------------------------
// ascii85_stream_encoder
// Byte stream to ASCII85 text encoder with a configurable line length.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one raw byte per beat, tlast on the final byte of a stream.
//   m_axis carries one text character per beat, tlast on the closing '>'.
//   cfg_wr_en/cfg_wr_data write groups_per_line (reset 20) while idle.
// Path: a digit group goes from its fourth accepted byte to m_axis through
//   the queue write, a load step, five digit steps through the reciprocal
//   multiplier, the handoff and the output register; a 'z' group skips the
//   digit steps.
// Throughput: the digit unit converts the next group while the output stage
//   sends the characters of the last, one per cycle while m_axis_tready is
//   high; a digit group has up to 8 characters (with newline and end), and
//   a 'z' group is bound by its 4 input beats.
// Reset clears the group, line count, queue and output stage; no clearing pass.
// A stalled receiver holds the output beat; the job queue then fills and
//   s_axis_tready drops until characters drain again.
// ----------------------------------------------------------------------------

module ascii85_stream_encoder #(
  parameter int QUEUE_DEPTH = a85enc_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // last_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_char
  output logic       m_axis_tlast,   // out_last
  input  logic       cfg_wr_en,
  input  logic [5:0] cfg_wr_data
);

  a85enc_pkg::qstat_t qstat;
  a85enc_pkg::job_t   push_job;
  a85enc_pkg::job_t   pop_job;
  logic               push;
  logic               pop;

  // front: grouping and classification
  a85enc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .data_byte   (s_axis_tdata),
    .last_byte   (s_axis_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .qstat       (qstat),
    .push        (push),
    .push_job    (push_job)
  );

  // job queue
  a85enc_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .qstat    (qstat)
  );

  // back: digit conversion and character output
  a85enc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .qstat     (qstat),
    .pop_job   (pop_job),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_char  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ascii85 stream encoder. Raw bytes go in on
// s_axis with random gaps; every m_axis character is compared with typed
// row text or a bench encoder tracking group, line count and line length.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int DIR_ROWS       = 23;
  localparam int SETTLE_CYCLES  = 24;
  localparam int STALL_LIMIT    = 4000;
  localparam int PHASE_BYTES    = 18;

  // one row of the directed table; typed rows carry their expected text
  typedef struct packed {
    logic        cfg_en;
    logic [5:0]  cfg_val;
    logic [7:0]  data;
    logic        last;
    logic        typed;
    logic [3:0]  n_chars;
    logic [63:0] chars;   // first character in the highest used byte
  } dir_row_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // [7:0] data_byte
  logic       s_axis_tlast = 1'b0;    // last_byte
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] out_char
  logic       m_axis_tlast;           // out_last
  logic       cfg_wr_en = 1'b0;
  logic [5:0] cfg_wr_data = 6'd0;

  // bench copy of the encoder state
  logic [5:0]  line_len       = a85enc_pkg::GPL_RESET;
  logic [23:0] open_bytes     = '0;
  logic [1:0]  open_count     = '0;
  logic [5:0]  groups_on_line = '0;
  bit          record_chars   = 1'b1;

  text_beat_t pending_chars[$];

  int  errors        = 0;
  int  bytes_sent    = 0;
  int  streams_done  = 0;
  int  chars_checked = 0;
  int  idle_cycles   = 0;
  bit  send_busy     = 1'b1;
  bit  rx_busy       = 1'b1;

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  ascii85_stream_encoder u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  // directed table: extremes, zero groups, partial tails, zero line length
  function automatic dir_row_t dir_row(int k);
    case (k)
      0:          return '{1'b0, 6'd0, 8'h00, 1'b1, 1'b1, 4'd4, "!!~>"};
      1:          return '{1'b0, 6'd0, 8'hFF, 1'b1, 1'b0, 4'd0, 64'd0};
      2, 3, 4:    return '{1'b0, 6'd0, 8'h00, 1'b0, 1'b1, 4'd0, 64'd0};
      5:          return '{1'b0, 6'd0, 8'h00, 1'b1, 1'b1, 4'd3, "z~>"};
      6, 7, 8:    return '{1'b0, 6'd0, 8'hFF, 1'b0, 1'b1, 4'd0, 64'd0};
      9:          return '{1'b0, 6'd0, 8'hFF, 1'b1, 1'b1, 4'd7, "s8W-!~>"};
      10:         return '{1'b0, 6'd0, 8'h01, 1'b0, 1'b0, 4'd0, 64'd0};
      11:         return '{1'b0, 6'd0, 8'h02, 1'b0, 1'b0, 4'd0, 64'd0};
      12:         return '{1'b0, 6'd0, 8'h03, 1'b1, 1'b0, 4'd0, 64'd0};
      13:         return '{1'b0, 6'd0, 8'hA5, 1'b0, 1'b0, 4'd0, 64'd0};
      14:         return '{1'b0, 6'd0, 8'h5A, 1'b1, 1'b0, 4'd0, 64'd0};
      15:         return '{1'b1, 6'd0, 8'h00, 1'b0, 1'b1, 4'd0, 64'd0};
      16, 17:     return '{1'b0, 6'd0, 8'h00, 1'b0, 1'b1, 4'd0, 64'd0};
      18:         return '{1'b0, 6'd0, 8'h00, 1'b0, 1'b1, 4'd2, "z\n"};
      19, 20, 21: return '{1'b0, 6'd0, 8'h00, 1'b0, 1'b1, 4'd0, 64'd0};
      default:    return '{1'b0, 6'd0, 8'h00, 1'b1, 1'b1, 4'd4, "z\n~>"};
    endcase
  endfunction

  function automatic void push_char(logic [7:0] ch, logic last);
    if (record_chars)
      pending_chars.push_back('{ch, last});
  endfunction

  // leading base-85 digits of a word, most significant first
  function automatic void emit_digits(logic [31:0] value, int count);
    logic [7:0] dig [5];
    logic [31:0] rem;
    for (int i = 4; i >= 0; i--) begin
      rem    = value % 32'd85;
      dig[i] = rem[7:0] + a85enc_pkg::CH_BANG;
      value  = value / 32'd85;
    end
    for (int i = 0; i < count; i++)
      push_char(dig[i], 1'b0);
  endfunction

  // expected characters for one accepted byte
  function automatic void encode_byte(logic [7:0] d, logic l);
    logic [31:0] joined;
    logic [5:0]  lim;
    logic [1:0]  pos;
    pos    = open_count;
    joined = {open_bytes, d};
    lim    = (line_len == 6'd0) ? 6'd1 : line_len;
    if (pos == 2'd3) begin
      if (joined == 32'd0)
        push_char(a85enc_pkg::CH_Z, 1'b0);
      else
        emit_digits(joined, 5);
      groups_on_line = groups_on_line + 6'd1;
      if (groups_on_line >= lim) begin
        push_char(a85enc_pkg::CH_NL, 1'b0);
        groups_on_line = '0;
      end
      open_bytes = '0;
      open_count = '0;
    end else begin
      open_bytes = joined[23:0];
      open_count = pos + 2'd1;
    end
    if (l) begin
      if (pos != 2'd3)
        emit_digits(joined << (8 * (3 - int'(pos))), int'(pos) + 2);
      push_char(a85enc_pkg::CH_TILDE, 1'b0);
      push_char(a85enc_pkg::CH_GT, 1'b1);
      open_bytes     = '0;
      open_count     = '0;
      groups_on_line = '0;
    end
  endfunction

  // one input beat; returns in the time step of its acceptance
  task automatic send_byte(input logic [7:0] d, input logic l);
    int gap;
    gap = send_busy ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tlast  <= l;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    encode_byte(d, l);
    bytes_sent++;
    if (l)
      streams_done++;
  endtask

  // hold off input until all text is out and the block has gone quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_line_len(input logic [5:0] v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    line_len = v;
  endtask

  function automatic logic [7:0] rand_byte(bit zero_heavy);
    int r;
    r = $urandom_range(0, 9);
    if (zero_heavy)
      return (r < 8) ? 8'h00 : 8'($urandom);
    if (r < 2)
      return 8'h00;
    if (r == 2)
      return 8'hFF;
    return 8'($urandom);
  endfunction

  task automatic send_stream(input int len);
    bit zero_heavy;
    zero_heavy = ($urandom_range(0, 3) == 0);
    send_busy  = ($urandom_range(0, 9) < 7);
    for (int i = 0; i < len; i++)
      send_byte(rand_byte(zero_heavy), i == len - 1);
  endtask

  // stimulus
  initial begin : stim
    dir_row_t row;
    int       phase_start;
    logic [5:0] phase_len [6];
    phase_len = '{6'd63, 6'd1, 6'd2, 6'd3, 6'd0, 6'd4};
    phase_len[5] = 6'($urandom_range(4, 9));
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows
    for (int k = 0; k < DIR_ROWS; k++) begin
      row = dir_row(k);
      if (row.cfg_en)
        set_line_len(row.cfg_val);
      record_chars = !row.typed;
      send_byte(row.data, row.last);
      record_chars = 1'b1;
      if (row.typed)
        for (int i = 0; i < int'(row.n_chars); i++)
          pending_chars.push_back('{row.chars[8 * (int'(row.n_chars) - 1 - i) +: 8],
                                   row.last && (i == int'(row.n_chars) - 1)});
    end

    // random phases, one line length each
    for (int p = 0; p < 6; p++) begin
      set_line_len(phase_len[p]);
      if (phase_len[p] == 6'd63) begin
        // long enough to close one full line, sometimes exactly on the last byte
        send_stream(252 + $urandom_range(0, 7));
      end else begin
        phase_start = bytes_sent;
        while (bytes_sent - phase_start < PHASE_BYTES)
          send_stream(($urandom_range(0, 3) == 0) ? $urandom_range(1, 4)
                                                  : $urandom_range(1, 16));
      end
    end

    settle();
    $display("covered %0d bytes in %0d streams, %0d characters checked",
             bytes_sent, streams_done, chars_checked);
    $display("line lengths 20 (reset), 0, 1, 2, 3, 63 and %0d, with random stalls",
             phase_len[5]);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // receiver with random stalls and stall-free stretches
  initial begin : rx
    int stall;
    text_beat_t want;
    while (rst) @(posedge clk);
    forever begin
      if (chars_checked % 32 == 0)
        rx_busy = ($urandom_range(0, 3) != 0);
      stall = rx_busy ? $urandom_range(0, 16) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      chars_checked++;
      if (pending_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, actual char %02h last %0b",
                 $time, m_axis_tdata, m_axis_tlast);
      end else begin
        want = pending_chars.pop_front();
        if (m_axis_tdata !== want.ch) begin
          errors++;
          $display("%0t: char mismatch, expected %02h, actual %02h",
                   $time, want.ch, m_axis_tdata);
        end
        if (m_axis_tlast !== want.last) begin
          errors++;
          $display("%0t: tlast mismatch, expected %0b, actual %0b",
                   $time, want.last, m_axis_tlast);
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d characters still expected",
               $time, idle_cycles, pending_chars.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
